FILE: design/erld_pkg.sv
// Shared types and constants for the extent run list decoder.
// Holds phase and status codes, the result word type and queue sizing.
// No dependencies.
`timescale 1ns / 1ps

package erld_pkg;

  // Decoder phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_OFFSET = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_END     = 3'd1;
  localparam logic [2:0] ST_BADSIZE = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_NEG     = 3'd4;

  // Result queue sizing: one byte yields at most two results
  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int CNT_W     = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] vcn_start;
    logic [63:0] cluster_count;
    logic [62:0] lcn_start;
    logic        sparse;
    logic        list_end;
  } result_t;

endpackage

FILE: design/extent_run_list_decoder_top.sv
// Extent run list decoder top level: byte input register, decode logic,
// result queue and start-VCN configuration register. Depends on erld_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries one run list byte per word,
//   with in_last_byte high on the final byte of a buffer. Output channel
//   (out_valid / out_stall) carries one result word: a decoded run (status 0)
//   or a list end / error status with out_list_end high.
//   cfg_wr_en / cfg_wr_data load start_vcn; it is sampled when the first byte
//   of each list is decoded, so load it while the block is idle.
// Throughput: one byte per cycle while the queue has room. An accepted byte
//   waits in the input register and is decoded there once the queue has room;
//   its results are registered into the queue, whose head word drives the
//   output. A byte that ends a run on the last buffer byte gives two results,
//   drained one per cycle while out_stall is low.
// Stalls: results wait in a four-word queue; the input stalls only when the
//   queue has fewer than two free words, which the output stall alone sets.
// Reset: rst_n (synchronous, active low) empties the queue and input
//   register, clears start_vcn and arms the block for a new list.
module extent_run_list_decoder_top
  import erld_pkg::*;
#(
  parameter int MAX_FIELD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  // input bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_run_byte,
  input  logic        in_last_byte,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [63:0] out_vcn_start,
  output logic [63:0] out_cluster_count,
  output logic [62:0] out_lcn_start,
  output logic        out_sparse,
  output logic        out_list_end
);

  localparam logic [3:0] MaxBytes = 4'(MAX_FIELD_BYTES);

  // input register
  logic        in_v_r;
  logic [7:0]  byte_r;
  logic        last_r;

  // decode state
  logic [1:0]  phase_r, phase_nxt;
  logic        fresh_r, fresh_nxt;
  logic [3:0]  len_bytes_r, len_bytes_nxt;
  logic [3:0]  off_bytes_r, off_bytes_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] len_acc_r, len_acc_nxt;
  logic [63:0] off_acc_r, off_acc_nxt;
  logic [63:0] lcn_r, lcn_nxt;
  logic [63:0] vcn_r, vcn_nxt;
  logic [63:0] start_vcn_r;

  // result queue
  result_t            res_q_r [RES_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  // decode datapath
  logic        advance, proc, pop;
  logic [1:0]  cur_phase;
  logic [63:0] cur_vcn, cur_lcn;
  logic [63:0] shifted, len_acc_or, off_acc_or, run_len;
  logic [3:0]  pos_inc;
  logic [5:0]  sign_idx;
  logic [63:0] ext_mask, delta, lcn_sum;
  logic [3:0]  hdr_lb, hdr_ob;
  logic [1:0]  push_n;
  result_t     res0, res1, stop_res, run_res;

  // Accept a new byte whenever the queue can absorb two results
  assign advance  = (cnt_r <= CNT_W'(RES_DEPTH - 2));
  assign proc     = in_v_r && advance;
  assign in_stall = in_v_r && !advance;
  assign pop      = out_valid && !out_stall;

  // Hold the input byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      byte_r <= in_run_byte;
      last_r <= in_last_byte;
    end
  end

  // Load start_vcn
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_vcn_r <= '0;
    end else if (cfg_wr_en) begin
      start_vcn_r <= cfg_wr_data;
    end
  end

  // Field bytes, sign extension and the running LCN sum
  always_comb begin
    cur_phase  = fresh_r ? PH_HEADER : phase_r;
    cur_vcn    = fresh_r ? start_vcn_r : vcn_r;
    cur_lcn    = fresh_r ? 64'd0 : lcn_r;
    shifted    = {56'd0, byte_r} << {pos_r[2:0], 3'b000};
    len_acc_or = len_acc_r | shifted;
    off_acc_or = off_acc_r | shifted;
    pos_inc    = pos_r + 4'd1;
    run_len    = (cur_phase == PH_LENGTH) ? len_acc_or : len_acc_r;
    sign_idx   = {off_bytes_r[2:0] - 3'd1, 3'b111};
    ext_mask   = ~64'd0 << {off_bytes_r, 3'b000};
    delta      = off_acc_or[sign_idx] ? (off_acc_or | ext_mask) : off_acc_or;
    lcn_sum    = cur_lcn + delta;
    hdr_lb     = byte_r[3:0];
    hdr_ob     = byte_r[7:4];
  end

  // Result word templates
  always_comb begin
    stop_res          = '0;
    stop_res.list_end = 1'b1;
    run_res               = '0;
    run_res.status        = ST_RUN;
    run_res.vcn_start     = cur_vcn;
    run_res.cluster_count = run_len;
    run_res.lcn_start     = (cur_phase == PH_LENGTH) ? 63'd0 : lcn_sum[62:0];
    run_res.sparse        = (cur_phase == PH_LENGTH);
  end

  // Decode one byte
  always_comb begin
    phase_nxt     = cur_phase;
    fresh_nxt     = fresh_r;
    len_bytes_nxt = len_bytes_r;
    off_bytes_nxt = off_bytes_r;
    pos_nxt       = pos_r;
    len_acc_nxt   = len_acc_r;
    off_acc_nxt   = off_acc_r;
    lcn_nxt       = cur_lcn;
    vcn_nxt       = cur_vcn;
    push_n        = 2'd0;
    res0          = stop_res;
    res1          = stop_res;
    res1.status   = ST_END;

    unique case (cur_phase)
      PH_HEADER: begin
        len_bytes_nxt = hdr_lb;
        off_bytes_nxt = hdr_ob;
        if (byte_r == 8'd0) begin
          push_n = 2'd1; res0.status = ST_END; phase_nxt = PH_SKIP;
        end else if (hdr_lb == 4'd0 || hdr_lb > MaxBytes || hdr_ob > MaxBytes) begin
          push_n = 2'd1; res0.status = ST_BADSIZE; phase_nxt = PH_SKIP;
        end else if (last_r) begin
          push_n = 2'd1; res0.status = ST_TRUNC; phase_nxt = PH_SKIP;
        end else begin
          pos_nxt     = 4'd0;
          len_acc_nxt = '0;
          off_acc_nxt = '0;
          phase_nxt   = PH_LENGTH;
        end
      end
      PH_LENGTH, PH_OFFSET: begin
        pos_nxt = pos_inc;
        if (cur_phase == PH_LENGTH) begin
          len_acc_nxt = len_acc_or;
        end else begin
          off_acc_nxt = off_acc_or;
        end
        priority if (cur_phase == PH_LENGTH && pos_inc >= len_bytes_r &&
                     off_bytes_r != 4'd0) begin
          // length done, offset follows
          if (last_r) begin
            push_n = 2'd1; res0.status = ST_TRUNC; phase_nxt = PH_SKIP;
          end else begin
            pos_nxt   = 4'd0;
            phase_nxt = PH_OFFSET;
          end
        end else if ((cur_phase == PH_LENGTH && pos_inc >= len_bytes_r) ||
                     (cur_phase == PH_OFFSET && pos_inc >= off_bytes_r)) begin
          // run complete
          if (cur_phase == PH_OFFSET) begin
            lcn_nxt = lcn_sum;
          end
          if (cur_phase == PH_OFFSET && lcn_sum[63]) begin
            push_n = 2'd1; res0.status = ST_NEG; phase_nxt = PH_SKIP;
          end else begin
            res0      = run_res;
            vcn_nxt   = cur_vcn + run_len;
            phase_nxt = PH_HEADER;
            if (last_r) begin
              push_n    = 2'd2;
              phase_nxt = PH_SKIP;
            end else begin
              push_n = 2'd1;
            end
          end
        end else if (last_r) begin
          push_n = 2'd1; res0.status = ST_TRUNC; phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase

    // Rearm for a new list after the buffer's last byte
    if (last_r) begin
      phase_nxt = PH_HEADER;
      fresh_nxt = 1'b1;
    end else begin
      fresh_nxt = 1'b0;
    end
  end

  // Advance decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      fresh_r <= 1'b1;
    end else if (proc) begin
      phase_r <= phase_nxt;
      fresh_r <= fresh_nxt;
    end
    if (proc) begin
      len_bytes_r <= len_bytes_nxt;
      off_bytes_r <= off_bytes_nxt;
      pos_r       <= pos_nxt;
      len_acc_r   <= len_acc_nxt;
      off_acc_r   <= off_acc_nxt;
      lcn_r       <= lcn_nxt;
      vcn_r       <= vcn_nxt;
    end
  end

  // Push results, drop the head word once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (proc) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + (proc ? CNT_W'(push_n) : CNT_W'(0)) - CNT_W'(pop);
    end
    if (proc && push_n != 2'd0) begin
      res_q_r[wr_ptr_r] <= res0;
    end
    if (proc && push_n == 2'd2) begin
      res_q_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  // Drive the head word
  assign out_valid         = (cnt_r != '0);
  assign out_status        = res_q_r[rd_ptr_r].status;
  assign out_vcn_start     = res_q_r[rd_ptr_r].vcn_start;
  assign out_cluster_count = res_q_r[rd_ptr_r].cluster_count;
  assign out_lcn_start     = res_q_r[rd_ptr_r].lcn_start;
  assign out_sparse        = res_q_r[rd_ptr_r].sparse;
  assign out_list_end      = res_q_r[rd_ptr_r].list_end;

  // Queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  // Two results only for a run closed by the buffer's last byte
  a_pair_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && push_n == 2'd2) |-> (last_r && res0.status == ST_RUN))
    else $error("result pair without last byte");

  // Every non-run result closes the list
  a_stop_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && push_n != 2'd0 && res0.status != ST_RUN) |-> res0.list_end)
    else $error("status result without list end");

  // Skipped bytes produce nothing
  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && cur_phase == PH_SKIP) |-> (push_n == 2'd0))
    else $error("result while skipping");

  // The last byte rearms the decoder
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && last_r) |=> (fresh_r && phase_r == PH_HEADER))
    else $error("decoder not rearmed after last byte");

endmodule

FILE: tb/extent_run_list_decoder_top_tb.sv
// Testbench for extent_run_list_decoder_top: streams run list bytes and
// checks every result word against a byte-level decoder model in a scoreboard.
// Depends on erld_pkg and the decoder RTL.
`timescale 1ns / 1ps

module extent_run_list_decoder_top_tb
  import erld_pkg::*;
();

  localparam int FIELD_BYTES_MAX = 8;

  // Predicts result words per accepted byte and checks the output stream
  class run_list_scoreboard;
    result_t expected_q[$];
    int mismatches;

    logic [63:0] start_vcn;
    logic        list_fresh;
    logic [1:0]  phase;
    logic [3:0]  len_size;
    logic [3:0]  off_size;
    logic [3:0]  pos;
    logic [63:0] len_acc;
    logic [63:0] off_acc;
    logic [63:0] lcn;
    logic [63:0] vcn;

    function new();
      mismatches = 0;
      start_vcn  = '0;
      list_fresh = 1'b1;
      phase      = PH_HEADER;
      len_size   = '0;
      off_size   = '0;
      pos        = '0;
      len_acc    = '0;
      off_acc    = '0;
      lcn        = '0;
      vcn        = '0;
    endfunction

    function void set_start_vcn(logic [63:0] value);
      start_vcn = value;
    endfunction

    function void emit(logic [2:0] st, logic [63:0] vcn_v, logic [63:0] cnt_v,
                       logic [63:0] lcn_v, logic sp, logic le);
      result_t r;
      r.status        = st;
      r.vcn_start     = vcn_v;
      r.cluster_count = cnt_v;
      r.lcn_start     = lcn_v[62:0];
      r.sparse        = sp;
      r.list_end      = le;
      expected_q = {expected_q, r};
    endfunction

    // Emit a status word and skip the rest of the buffer
    function void abort_list(logic [2:0] st);
      emit(st, '0, '0, '0, 1'b0, 1'b1);
      phase = PH_SKIP;
    endfunction

    // Apply the offset delta and emit the finished run
    function void close_run(logic sparse_run, logic last);
      logic [63:0] delta;
      logic [63:0] lcn_v;
      lcn_v = '0;
      if (!sparse_run) begin
        delta = off_acc;
        if (off_size < 4'd8 && delta[8 * off_size - 1])
          delta = delta | (~64'd0 << (8 * off_size));
        lcn = lcn + delta;
        if (lcn[63]) begin
          abort_list(ST_NEG);
          return;
        end
        lcn_v = lcn;
      end
      emit(ST_RUN, vcn, len_acc, lcn_v, sparse_run, 1'b0);
      vcn   = vcn + len_acc;
      phase = PH_HEADER;
      if (last)
        abort_list(ST_END);
    endfunction

    // Note one accepted byte and queue the results it causes
    function void note_byte(logic [7:0] b, logic last);
      if (list_fresh) begin
        vcn        = start_vcn;
        lcn        = '0;
        phase      = PH_HEADER;
        list_fresh = 1'b0;
      end
      case (phase)
        PH_HEADER: begin
          if (b == 8'h00) begin
            abort_list(ST_END);
          end else begin
            len_size = b[3:0];
            off_size = b[7:4];
            if (len_size == 0 || len_size > FIELD_BYTES_MAX || off_size > FIELD_BYTES_MAX) begin
              abort_list(ST_BADSIZE);
            end else if (last) begin
              abort_list(ST_TRUNC);
            end else begin
              pos     = '0;
              len_acc = '0;
              off_acc = '0;
              phase   = PH_LENGTH;
            end
          end
        end
        PH_LENGTH: begin
          len_acc = len_acc | ({56'd0, b} << (8 * pos));
          pos     = pos + 4'd1;
          if (pos >= len_size) begin
            if (off_size == 0) begin
              close_run(1'b1, last);
            end else if (last) begin
              abort_list(ST_TRUNC);
            end else begin
              pos   = '0;
              phase = PH_OFFSET;
            end
          end else if (last) begin
            abort_list(ST_TRUNC);
          end
        end
        PH_OFFSET: begin
          off_acc = off_acc | ({56'd0, b} << (8 * pos));
          pos     = pos + 4'd1;
          if (pos >= off_size)
            close_run(1'b0, last);
          else if (last)
            abort_list(ST_TRUNC);
        end
        default: ;
      endcase
      if (last) begin
        phase      = PH_HEADER;
        list_fresh = 1'b1;
      end
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one result word against the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result word with none pending: status %0d", got.status);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare("status", 64'(want.status), 64'(got.status));
      compare("vcn_start", want.vcn_start, got.vcn_start);
      compare("cluster_count", want.cluster_count, got.cluster_count);
      compare("lcn_start", 64'(want.lcn_start), 64'(got.lcn_start));
      compare("sparse", 64'(want.sparse), 64'(got.sparse));
      compare("list_end", 64'(want.list_end), 64'(got.list_end));
    endfunction
  endclass

  typedef struct packed {
    logic [7:0] run_byte;
    logic       last_byte;
  } stream_word_t;

  // Directed words as {last_byte, run_byte}
  localparam logic [8:0] DIRECTED [21] = '{
    9'h011, 9'h0FF, 9'h07F,          // run whose length wraps the VCN
    9'h001, 9'h080,                  // sparse run
    9'h011, 9'h001, 9'h080, 9'h1EE,  // negative cluster, then skipped byte
    9'h100,                          // zero header alone
    9'h009, 9'h1AB,                  // length size above max, then skip
    9'h190,                          // zero length size, offset size 9
    9'h111,                          // valid header on the last byte
    9'h001, 9'h103,                  // run ending on the last byte
    9'h012, 9'h101,                  // cut inside the length field
    9'h021, 9'h001, 9'h105           // cut inside the offset field
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_run_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [63:0] out_vcn_start;
  logic [63:0] out_cluster_count;
  logic [62:0] out_lcn_start;
  logic        out_sparse;
  logic        out_list_end;

  run_list_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  stream_word_t stim_q[$];
  stream_word_t run_q[$];

  extent_run_list_decoder_top #(
    .MAX_FIELD_BYTES(FIELD_BYTES_MAX)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_run_byte      (in_run_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_vcn_start    (out_vcn_start),
    .out_cluster_count(out_cluster_count),
    .out_lcn_start    (out_lcn_start),
    .out_sparse       (out_sparse),
    .out_list_end     (out_list_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Take result words and stall at random
  initial begin
    result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = {out_status, out_vcn_start, out_cluster_count, out_lcn_start,
               out_sparse, out_list_end};
        sb.check_result(got);
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic write_start_vcn(logic [63:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_start_vcn(value);
  endtask

  // Drive one word, hold it through stalls, note it once accepted
  task automatic send_word(stream_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_run_byte  <= w.run_byte;
    in_last_byte <= w.last_byte;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.note_byte(w.run_byte, w.last_byte);
  endtask

  task automatic send_all();
    foreach (stim_q[i])
      send_word(stim_q[i]);
    stim_q.delete();
    in_valid <= 1'b0;
  endtask

  // Wait for every result, then let bytes without results clear the pipe
  task automatic drain();
    while (sb.expected_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int field_size();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 8);
  endfunction

  function automatic void push_word(logic [7:0] b, logic last);
    stream_word_t w;
    w.run_byte  = b;
    w.last_byte = last;
    stim_q = {stim_q, w};
  endfunction

  // Build one well-formed run into run_q; offsets lean positive
  task automatic build_run();
    int len_n;
    int off_n;
    logic [7:0] b;
    stream_word_t w;
    run_q.delete();
    len_n = field_size();
    off_n = ($urandom_range(0, 4) == 0) ? 0 : field_size();
    w.last_byte = 1'b0;
    w.run_byte  = {off_n[3:0], len_n[3:0]};
    run_q = {run_q, w};
    for (int i = 0; i < len_n + off_n; i++) begin
      b = 8'($urandom);
      if (i == len_n + off_n - 1 && off_n != 0 && $urandom_range(0, 3) != 0)
        b[7] = 1'b0;
      w.run_byte = b;
      run_q = {run_q, w};
    end
  endtask

  // Push an ending byte followed by a few skipped bytes up to the buffer end
  function automatic void push_tail(logic [7:0] first);
    int junk;
    junk = $urandom_range(0, 3);
    push_word(first, junk == 0);
    for (int i = 1; i <= junk; i++)
      push_word(8'($urandom), i == junk);
  endfunction

  // Build one buffer: runs plus an ending, or plain noise
  task automatic build_list();
    int n_runs;
    int ending;
    int cut;
    logic [7:0] hdr;
    n_runs = $urandom_range(0, 4);
    ending = $urandom_range(0, 9);
    if (ending == 9) begin
      n_runs = $urandom_range(1, 6);
      for (int i = 1; i <= n_runs; i++)
        push_word(8'($urandom), i == n_runs);
      return;
    end
    repeat (n_runs) begin
      build_run();
      foreach (run_q[i])
        stim_q = {stim_q, run_q[i]};
    end
    if (ending < 4) begin
      push_tail(8'h00);
    end else if (ending < 7) begin
      build_run();
      run_q[run_q.size() - 1].last_byte = 1'b1;
      foreach (run_q[i])
        stim_q = {stim_q, run_q[i]};
    end else if (ending < 8) begin
      build_run();
      cut = $urandom_range(0, run_q.size() - 2);
      for (int i = 0; i <= cut; i++)
        push_word(run_q[i].run_byte, i == cut);
    end else begin
      do hdr = 8'($urandom);
      while (hdr == 8'h00 || (hdr[3:0] != 0 && hdr[3:0] <= FIELD_BYTES_MAX &&
                              hdr[7:4] <= FIELD_BYTES_MAX));
      push_tail(hdr);
    end
  endtask

  initial begin
    logic [63:0] vcn_settings [6];
    vcn_settings = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom},
                     64'h8000_0000_0000_0000, {$urandom, $urandom}, 64'h1};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words
    write_start_vcn(64'hFFFF_FFFF_FFFF_FF80);
    foreach (DIRECTED[i])
      push_word(DIRECTED[i][7:0], DIRECTED[i][8]);
    send_idle_pct = 19;
    recv_idle_pct = 65;
    send_all();

    // Random buffers under each idle mix and start VCN setting
    for (int p = 0; p < 6; p++) begin
      drain();
      write_start_vcn(vcn_settings[p]);
      case (p / 2)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (stim_q.size() < 115)
        build_list();
      send_all();
    end

    drain();
    if (sb.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
design/erld_pkg.sv
design/extent_run_list_decoder_top.sv
tb/extent_run_list_decoder_top_tb.sv
